// File: design/assert_macros.svh
// Assertion macros used by the encoder top level.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that an implication holds at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: design/orte_pkg.sv
package orte_pkg;

    // Largest map, in cells; run lengths saturate here.
    localparam int MAX_CELLS = 1048576;

    // Count decimal digits of a constant, at elaboration only.
    function automatic int dec_digits(longint v);
        longint p;
        int     n;
        p = 10;
        n = 1;
        while (p <= v) begin
            p = p * 10;
            n++;
        end
        return n;
    endfunction

    localparam int LEN_W     = $clog2(MAX_CELLS + 1);
    localparam int DIGITS    = dec_digits(longint'(MAX_CELLS));
    localparam int BCD_W     = 4 * DIGITS;
    localparam int BIT_CNT_W = $clog2(LEN_W + 1);
    localparam int DIG_CNT_W = $clog2(DIGITS + 1);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CELLS);

    // Cell classes.
    localparam logic [1:0] CLS_UNKNOWN  = 2'd0;
    localparam logic [1:0] CLS_FREE     = 2'd1;
    localparam logic [1:0] CLS_OCCUPIED = 2'd2;

    localparam logic [6:0] THRESH_RESET = 7'd50;

    localparam logic [7:0] CHAR_U    = 8'h75;
    localparam logic [7:0] CHAR_F    = 8'h66;
    localparam logic [7:0] CHAR_O    = 8'h6F;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    // One token to emit: class, run length, and whether it ends the stream.
    typedef struct packed {
        logic [1:0]       cls;
        logic [LEN_W-1:0] len;
        logic             final_tok;
    } t_tok_job;

    function automatic logic [7:0] class_letter(logic [1:0] cls);
        logic [7:0] ch;
        case (cls)
            CLS_UNKNOWN: ch = CHAR_U;
            CLS_FREE:    ch = CHAR_F;
            default:     ch = CHAR_O;
        endcase
        return ch;
    endfunction

endpackage

// File: design/occupancy_rle_text_encoder.sv
// Channel   Handshake                   Payload
// cells in  i_in_valid / o_in_ready     i_cell_value[7:0] signed, i_last_cell
// chars out o_out_valid / i_out_ready   o_token_byte[7:0], o_token_end, o_stream_end
// config    i_cfg_we                    i_cfg_wdata[6:0] occupied threshold
//
// A cell that continues its run emits nothing, unless it is the last cell.
// A token's length is converted to BCD and captured, then leading zeros are
// skipped and the digits sent; the letter goes out during conversion.
// Input waits while a token is queued.
// Reset is synchronous, active low; threshold returns to 50, no run open.
// A stalled output holds its word; the emitter and the input wait on it.
`include "assert_macros.svh"

module occupancy_rle_text_encoder
    import orte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic signed [7:0] i_cell_value,
    input  logic              i_last_cell,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_token_byte,
    output logic              o_token_end,
    output logic              o_stream_end
);

    logic [6:0]       r_thresh;
    logic [1:0]       r_cls;
    logic [LEN_W-1:0] r_len;
    logic             r_open;
    logic             r_job_valid;
    t_tok_job         r_job;
    logic             r_pend;
    logic [1:0]       r_pend_cls;

    logic             in_acc;
    logic [1:0]       cell_cls;
    logic             same;
    logic [LEN_W-1:0] len_new;
    logic             emit_idle;
    logic             emit_start;

    // Class the incoming cell.
    always_comb begin
        if (i_cell_value[7]) begin
            cell_cls = CLS_UNKNOWN;
        end else if (i_cell_value[6:0] < r_thresh) begin
            cell_cls = CLS_FREE;
        end else begin
            cell_cls = CLS_OCCUPIED;
        end
    end

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_job_valid && !r_pend;
    assign same       = r_open && (cell_cls == r_cls);
    assign len_new    = (r_len < MAX_LEN) ? r_len + 1'b1 : r_len;
    assign emit_start = r_job_valid && emit_idle;

    // Hold the threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // Track the current run and queue finished tokens.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls       <= CLS_UNKNOWN;
            r_len       <= '0;
            r_open      <= 1'b0;
            r_job_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            // Hand a token to the emitter, then bring up the queued one.
            if (emit_start) begin
                r_job_valid <= r_pend;
                if (r_pend) begin
                    r_job.cls       <= r_pend_cls;
                    r_job.len       <= LEN_W'(1);
                    r_job.final_tok <= 1'b1;
                    r_pend          <= 1'b0;
                end
            end
            if (in_acc) begin
                if (same) begin
                    if (i_last_cell) begin
                        r_job_valid     <= 1'b1;
                        r_job.cls       <= r_cls;
                        r_job.len       <= len_new;
                        r_job.final_tok <= 1'b1;
                    end
                end else if (r_open) begin
                    r_job_valid     <= 1'b1;
                    r_job.cls       <= r_cls;
                    r_job.len       <= r_len;
                    r_job.final_tok <= 1'b0;
                    r_pend          <= i_last_cell;
                    r_pend_cls      <= cell_cls;
                end else if (i_last_cell) begin
                    r_job_valid     <= 1'b1;
                    r_job.cls       <= cell_cls;
                    r_job.len       <= LEN_W'(1);
                    r_job.final_tok <= 1'b1;
                end
                if (i_last_cell) begin
                    r_open <= 1'b0;
                    r_cls  <= CLS_UNKNOWN;
                    r_len  <= '0;
                end else begin
                    r_open <= 1'b1;
                    r_cls  <= same ? r_cls : cell_cls;
                    r_len  <= same ? len_new : LEN_W'(1);
                end
            end
        end
    end

    orte_tok_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (emit_start),
        .i_job        (r_job),
        .o_idle       (emit_idle),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_token_byte (o_token_byte),
        .o_token_end  (o_token_end),
        .o_stream_end (o_stream_end)
    );

    // A queued second token always has a first one ahead of it.
    `ASSERT_CLK(a_pend_behind_job, i_clk, i_rst_n, r_pend |-> r_job_valid)
    // The stream ends only on the last character of a token.
    `ASSERT_CLK(a_stream_end_tok, i_clk, i_rst_n, (o_out_valid && o_stream_end) |-> o_token_end)
    // The final cell closes the run.
    `ASSERT_CLK(a_last_closes, i_clk, i_rst_n, (in_acc && i_last_cell) |=> !r_open)
    // An open run never has zero length.
    `ASSERT_NEVER(a_open_len, i_clk, i_rst_n, r_open && (r_len == '0))

endmodule

// File: design/orte_bcd_conv.sv
module orte_bcd_conv
    import orte_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [LEN_W-1:0] i_value,
    output logic             o_busy,
    output logic [BCD_W-1:0] o_bcd
);

    logic [LEN_W-1:0]     r_bin, n_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [BCD_W-1:0]     adj;
    logic [BIT_CNT_W-1:0] r_cnt;
    logic                 r_busy;

    // Add three to every digit of five or more, then shift in the next bit.
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                      : r_bcd[d*4 +: 4];
        end
        n_bcd = (adj << 1) | BCD_W'(r_bin[LEN_W-1]);
        n_bin = r_bin << 1;
    end

    // Load on start, then shift one binary bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= BIT_CNT_W'(LEN_W);
            r_bin  <= i_value;
            r_bcd  <= '0;
        end else if (r_busy) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == BIT_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_bcd  = r_bcd;

endmodule

// File: design/orte_tok_emit.sv
module orte_tok_emit
    import orte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_tok_job   i_job,
    output logic       o_idle,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_token_byte,
    output logic       o_token_end,
    output logic       o_stream_end
);

    typedef enum logic [2:0] {
        E_IDLE,
        E_LETTER,
        E_WAIT,
        E_SKIP,
        E_DIGIT
    } t_emit_state;

    t_emit_state          r_state;
    logic [1:0]           r_cls;
    logic                 r_final;
    logic [BCD_W-1:0]     r_digits;
    logic [DIG_CNT_W-1:0] r_left;
    logic                 r_out_valid;
    logic [7:0]           r_byte;
    logic                 r_tend;
    logic                 r_send;

    logic                 conv_busy;
    logic [BCD_W-1:0]     conv_bcd;
    logic [3:0]           top_digit;
    logic                 slot_free;
    logic                 last_digit;
    logic                 out_load;

    orte_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_value (i_job.len),
        .o_busy  (conv_busy),
        .o_bcd   (conv_bcd)
    );

    assign top_digit  = r_digits[BCD_W-1 -: 4];
    assign slot_free  = !r_out_valid || i_out_ready;
    assign last_digit = (r_left == DIG_CNT_W'(1));
    assign out_load   = slot_free && (r_state == E_LETTER || r_state == E_DIGIT);

    // Sequence letter, conversion wait, leading-zero skip and digits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            // Raise a word on a load, drop it once it is taken.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_cls   <= i_job.cls;
                        r_final <= i_job.final_tok;
                        r_state <= E_LETTER;
                    end
                end
                E_LETTER: begin
                    if (slot_free) begin
                        r_byte  <= class_letter(r_cls);
                        r_tend  <= 1'b0;
                        r_send  <= 1'b0;
                        r_state <= E_WAIT;
                    end
                end
                E_WAIT: begin
                    if (!conv_busy) begin
                        r_digits <= conv_bcd;
                        r_left   <= DIG_CNT_W'(DIGITS);
                        r_state  <= E_SKIP;
                    end
                end
                E_SKIP: begin
                    if (top_digit == 4'd0 && !last_digit) begin
                        r_digits <= r_digits << 4;
                        r_left   <= r_left - 1'b1;
                    end else begin
                        r_state <= E_DIGIT;
                    end
                end
                E_DIGIT: begin
                    if (slot_free) begin
                        r_byte   <= CHAR_ZERO | {4'd0, top_digit};
                        r_tend   <= last_digit;
                        r_send   <= last_digit && r_final;
                        r_digits <= r_digits << 4;
                        r_left   <= r_left - 1'b1;
                        if (last_digit) begin
                            r_state <= E_IDLE;
                        end
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_idle       = (r_state == E_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_token_byte = r_byte;
    assign o_token_end  = r_tend;
    assign o_stream_end = r_send;

endmodule
